>>> src/assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define BSRA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("background subtract: assertion failed");

// antecedent on one edge, consequent on the next
`define BSRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("background subtract: assertion failed");

`else

`define BSRA_ASSERT(lbl, prop)
`define BSRA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/bsra_pkg.sv
// Shared types and constants of the running-average background subtractor.
`default_nettype none

package bsra_pkg;

	localparam int MAX_PIXELS = 524288;
	localparam int CHANNELS   = 3;
	localparam int POS_W      = $clog2(MAX_PIXELS);
	localparam int SAMPLE_W   = 8;
	localparam int WORD_W     = CHANNELS * SAMPLE_W;
	localparam int ALPHA_W    = 17;
	localparam int THR_W      = 9;
	localparam int FRAME_W    = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int PROD_W     = SAMPLE_W + ALPHA_W;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE       = ALPHA_W'(65536);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = ALPHA_W'(3277);
	localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(25);
	localparam logic [FRAME_W-1:0] FRAME_RESET     = FRAME_W'(307200);
	localparam logic [FRAME_W-1:0] FRAME_MAX       = FRAME_W'(MAX_PIXELS);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [POS_W-1:0]    pos_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLEND_ALPHA  = 2'd0,
		REG_FG_THRESHOLD = 2'd1,
		REG_MASK_ENABLE  = 2'd2,
		REG_FRAME_PIXELS = 2'd3
	} cfg_reg_t;

	// last pixel index for a frame size, with 0 read as 1 and oversize clamped
	function automatic pos_t frame_last(input logic [FRAME_W-1:0] n);
		pos_t r;
		if (n == '0) begin
			r = '0;
		end else if (n > FRAME_MAX) begin
			r = POS_W'(FRAME_MAX - FRAME_W'(1));
		end else begin
			r = POS_W'(n - FRAME_W'(1));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/bsra_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module bsra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/bsra_lane.sv
// One colour channel: absolute difference and Q16 blend products.
`default_nettype none

module bsra_lane import bsra_pkg::*; (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire sample_t             x_s1,
	input  wire sample_t             bg_s1,
	input  wire logic [ALPHA_W-1:0]  alpha,
	input  wire logic [ALPHA_W-1:0]  alpha_inv,
	output sample_t                  diff_s2,
	output sample_t                  x_s2,
	output sample_t                  blend_s2
);

	logic [PROD_W-1:0] prod_bg_s2;
	logic [PROD_W-1:0] prod_x_s2;
	logic [PROD_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2    <= (x_s1 > bg_s1) ? (x_s1 - bg_s1) : (bg_s1 - x_s1);
			x_s2       <= x_s1;
			prod_bg_s2 <= PROD_W'(bg_s1) * PROD_W'(alpha_inv);
			prod_x_s2  <= PROD_W'(x_s1) * PROD_W'(alpha);
		end
	end

	// sum never exceeds 255 << 16, so bits above 23 stay clear
	assign sum      = prod_bg_s2 + prod_x_s2;
	assign blend_s2 = sum[SAMPLE_W+15:16];

endmodule

`default_nettype wire

>>> src/bsra_merge.sv
// Merges lane differences: maximum and foreground decision.
`default_nettype none

module bsra_merge import bsra_pkg::*; (
	input  wire sample_t            diff [CHANNELS],
	input  wire logic               seed,
	input  wire logic [THR_W-1:0]   threshold,
	output sample_t                 max_diff,
	output logic                    foreground
);

	sample_t m;

	always_comb begin
		m = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (diff[k] > m) begin
				m = diff[k];
			end
		end
		// seed words carry no detection
		if (seed) begin
			max_diff   = '0;
			foreground = 1'b0;
		end else begin
			max_diff   = m;
			foreground = (THR_W'(m) >= threshold);
		end
	end

endmodule

`default_nettype wire

>>> src/background_subtract_running_average_core.sv
// Running-average background subtractor. Takes one RGB pixel word per clock
// in raster order while in_stall is low and returns one result word per pixel,
// registered through stage 1, stage 2 and the output register: the largest channel
// difference from the stored background, a foreground flag (difference >= fg_threshold)
// and a last-pixel-of-frame flag. The background lives in a 524288 x 24 RAM (one write
// and one registered read port); three channel lanes work in parallel and a merge
// stage takes their maximum. Sustained rate is one pixel per clock while out_stall is
// low. With a frame size of one, each pixel hits the entry the previous one is still
// writing, so a pixel waits for that write-back before it enters stage 2. The RAM has
// no reset and no clearing pass: every position must be written by a seed word before
// it is compared against. The user must write registers only while the pipeline is
// empty; the block itself does not enforce it. cfg_ready is always high.
`default_nettype none

module background_subtract_running_average_core import bsra_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            chan_r,
	input  wire logic [7:0]            chan_g,
	input  wire logic [7:0]            chan_b,
	input  wire logic                  update_mask,
	input  wire logic                  seed,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       foreground,
	output logic [7:0]                 max_diff,
	output logic                       frame_end
);

	`include "assert_macros.svh"

	// configuration, stored already clamped
	logic [ALPHA_W-1:0] alpha_q;
	logic [THR_W-1:0]   thr_q;
	logic               mask_en_q;
	pos_t               frame_last_q;
	logic [ALPHA_W-1:0] alpha_inv;

	// position counter
	pos_t pos_q;
	logic fend_in;

	// pipeline control
	logic v_s1, v_s2, out_valid_q;
	logic acc, adv1, adv2;
	logic s1_free, s2_free, out_free, hazard;

	// stage 1: RAM data arrives
	pos_t                pos_s1;
	sample_t             x_s1 [CHANNELS];
	logic                mask_s1, seed_s1, fend_s1;
	logic                fwd_v_s1;
	logic [WORD_W-1:0]   fwd_d_s1;
	logic [WORD_W-1:0]   ram_rdata;
	logic [WORD_W-1:0]   bg_word;

	// stage 2: products registered in the lanes
	pos_t                pos_s2;
	logic                seed_s2, upd_s2, fend_s2;
	sample_t             diff_s2  [CHANNELS];
	sample_t             xo_s2    [CHANNELS];
	sample_t             blend_s2 [CHANNELS];

	// write-back
	logic                ram_we;
	logic [WORD_W-1:0]   ram_wdata;

	// merged result and output register
	sample_t             max_d;
	logic                fg;
	logic                fg_q, fend_q;
	sample_t             max_d_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= ALPHA_RESET;
			thr_q        <= THRESHOLD_RESET;
			mask_en_q    <= 1'b0;
			frame_last_q <= frame_last(FRAME_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BLEND_ALPHA: begin
					// learning rates above 1.0 saturate
					if (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) begin
						alpha_q <= ALPHA_ONE;
					end else begin
						alpha_q <= cfg_data[ALPHA_W-1:0];
					end
				end
				REG_FG_THRESHOLD: thr_q        <= cfg_data[THR_W-1:0];
				REG_MASK_ENABLE:  mask_en_q    <= cfg_data[0];
				REG_FRAME_PIXELS: frame_last_q <= frame_last(cfg_data[FRAME_W-1:0]);
				default: ;
			endcase
		end
	end

	assign alpha_inv = ALPHA_ONE - alpha_q;

	// ---------------- handshake and stage enables ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign adv2     = v_s2 && out_free;
	assign s2_free  = !v_s2 || adv2;
	// same entry as the word ahead: wait for its write-back, picked up by the snoop
	assign hazard   = v_s1 && v_s2 && (pos_s1 == pos_s2);
	assign adv1     = v_s1 && s2_free && !hazard;
	assign s1_free  = !v_s1 || adv1;
	assign in_stall = !s1_free;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= acc;
			end
			if (s2_free) begin
				v_s2 <= adv1;
			end
			if (out_free) begin
				out_valid_q <= adv2;
			end
		end
	end

	// ---------------- pixel position ----------------
	// a position at or past the last pixel also closes the frame
	assign fend_in = (pos_q >= frame_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= fend_in ? '0 : pos_q + POS_W'(1);
		end
	end

	// ---------------- background RAM ----------------
	bsra_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_PIXELS)
	) u_bg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_s2),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_s1  <= pos_q;
			mask_s1 <= update_mask;
			seed_s1 <= seed;
			fend_s1 <= fend_in;
			for (int k = 0; k < CHANNELS; k++) begin
				if (k == 0) begin
					x_s1[k] <= chan_r;
				end else if (k == 1) begin
					x_s1[k] <= chan_g;
				end else if (k == 2) begin
					x_s1[k] <= chan_b;
				end else begin
					x_s1[k] <= '0;
				end
			end
		end
	end

	// write snoop: the RAM read misses a write on its own edge or while held here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_s1 <= 1'b0;
		end else if (acc) begin
			fwd_v_s1 <= ram_we && (pos_s2 == pos_q);
		end else if (ram_we && (pos_s2 == pos_s1)) begin
			fwd_v_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc ? (ram_we && (pos_s2 == pos_q)) : (ram_we && (pos_s2 == pos_s1))) begin
			fwd_d_s1 <= ram_wdata;
		end
	end

	assign bg_word = fwd_v_s1 ? fwd_d_s1 : ram_rdata;

	// ---------------- channel lanes ----------------
	for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
		bsra_lane u_lane (
			.clk       (clk),
			.en        (adv1),
			.x_s1      (x_s1[k]),
			.bg_s1     (bg_word[k*SAMPLE_W +: SAMPLE_W]),
			.alpha     (alpha_q),
			.alpha_inv (alpha_inv),
			.diff_s2   (diff_s2[k]),
			.x_s2      (xo_s2[k]),
			.blend_s2  (blend_s2[k])
		);
		// seed copies the pixel, otherwise the blended value
		assign ram_wdata[k*SAMPLE_W +: SAMPLE_W] = seed_s2 ? xo_s2[k] : blend_s2[k];
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk) begin
		if (adv1) begin
			pos_s2  <= pos_s1;
			seed_s2 <= seed_s1;
			upd_s2  <= !mask_en_q || mask_s1;
			fend_s2 <= fend_s1;
		end
	end

	// masked-off pixels leave their entry untouched
	assign ram_we = adv2 && (seed_s2 || upd_s2);

	bsra_merge u_merge (
		.diff       (diff_s2),
		.seed       (seed_s2),
		.threshold  (thr_q),
		.max_diff   (max_d),
		.foreground (fg)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (adv2) begin
			fg_q    <= fg;
			max_d_q <= max_d;
			fend_q  <= fend_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign foreground = fg_q;
	assign max_diff   = max_d_q;
	assign frame_end  = fend_q;

	// ---------------- assertions ----------------
	`BSRA_ASSERT_NEXT(a_snoop_catch, v_s1 && !acc && ram_we && (pos_s2 == pos_s1), fwd_v_s1)
	`BSRA_ASSERT_NEXT(a_pos_wrap, acc && fend_in, pos_q == '0)
	`BSRA_ASSERT_NEXT(a_s2_hold, v_s2 && !adv2, v_s2 && $stable(pos_s2))

endmodule

`default_nettype wire
